/* rtl/core/cwf_pkg.sv */
// ----------------------------------------------------------------------------
// cwf_pkg
// shared constants and types of the k by k window filter
// ----------------------------------------------------------------------------
package cwf_pkg;

    localparam int MAX_KERNEL  = 7;
    localparam int MAX_WIDTH   = 1024;
    localparam int SAMPLE_BITS = 16;
    localparam int MAX_HEIGHT  = 4096;
    localparam int STORE_COLS  = MAX_WIDTH + MAX_KERNEL;
    localparam int COEF_COUNT  = MAX_KERNEL * MAX_KERNEL;
    localparam int COL_BITS    = $clog2(STORE_COLS + 1);
    localparam int ROW_BITS    = 13;
    localparam int KSEL_BITS   = $clog2(MAX_KERNEL + 1);
    localparam int CIDX_BITS   = 6;
    localparam int SUM_BITS    = 40;
    localparam int PROD_BITS   = SAMPLE_BITS + 16;
    localparam int WC_BITS     = $clog2(MAX_WIDTH + 1);
    localparam int HC_BITS     = $clog2(MAX_HEIGHT + 1);
    localparam int OROW_BITS   = 12;
    localparam int OCOL_BITS   = 10;

    localparam logic MODE_COEF  = 1'b0;
    localparam logic MODE_PIXEL = 1'b1;

    localparam logic [1:0] REG_KERNEL = 2'd0;
    localparam logic [1:0] REG_WIDTH  = 2'd1;
    localparam logic [1:0] REG_HEIGHT = 2'd2;

    localparam int TAPS = MAX_KERNEL * MAX_KERNEL;

    typedef logic signed [SAMPLE_BITS-1:0] sample_t;
    typedef logic signed [15:0]            coef_t;
    typedef logic signed [SUM_BITS-1:0]    sum_t;

    typedef struct packed {
        logic [OROW_BITS-1:0] out_row;
        logic [OCOL_BITS-1:0] out_col;
        logic                 last_in_row;
        logic                 last_in_frame;
    } tag_t;

endpackage

/* rtl/core/cwf_tap_cell.sv */
// ----------------------------------------------------------------------------
// cwf_tap_cell
// one window row tap: sample shift, coefficient product, running sum handoff
// ----------------------------------------------------------------------------
module cwf_tap_cell
    import cwf_pkg::*;
(
    input  logic    clk,
    input  logic    advance,
    input  sample_t sample_in,
    output sample_t sample_out,
    input  coef_t   coef,
    input  logic    enable,
    input  sum_t    sum_in,
    output sum_t    sum_out
);

    sample_t sample_reg;
    logic signed [PROD_BITS-1:0] prod;

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            sample_reg <= sample_in;
        end
    end

    assign sample_out = sample_reg;
    assign prod       = enable ? PROD_BITS'(sample_reg * coef) : '0;
    assign sum_out    = sum_in + SUM_BITS'(prod);

endmodule

/* rtl/core/cwf_line_store.sv */
// ----------------------------------------------------------------------------
// cwf_line_store
// one row memory of the padded frame with registered read
// ----------------------------------------------------------------------------
module cwf_line_store
    import cwf_pkg::*;
(
    input  logic                clk,
    input  logic                wr_en,
    input  logic [COL_BITS-1:0] wr_addr,
    input  sample_t             wr_data,
    input  logic                rd_en,
    input  logic [COL_BITS-1:0] rd_addr,
    output sample_t             rd_data
);

    sample_t mem [STORE_COLS];
    sample_t rd_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_reg;

endmodule

/* rtl/core/conv2d_window_filter_core.sv */
// ----------------------------------------------------------------------------
// conv2d_window_filter_core
// k by k correlation over a padded raster stream
// ----------------------------------------------------------------------------
// s_axis items: mode 0 loads coefficient coef_index, mode 1 delivers one padded
// pixel in raster order. cfg writes set kernel_size (0), out_width (1) and
// out_height (2); the user must make these writes only while the block is idle,
// which the block itself does not enforce. each pixel is written into a row of
// line stores; the column of the last seven rows then shifts into a seven by
// seven window of tap cells, and a K kernel uses the lower right K by K cells.
// one item per cycle is taken while m_axis is not stalled. a pixel that closes
// a full window gives one result through the line store read, window shift and
// tap products, registered row sums, then the output register. sum holds the
// exact window sum, wrapped to 40 bits. a coefficient load takes effect for
// pixels accepted after it. a stalled m_axis holds its result and the whole
// pipeline with it; s_axis_tready drops in the same cycle, so input is taken
// only while the output register is empty or being drained. reset restores the
// default configuration and zeroes the coefficients and counters; the line
// stores need no clearing since every window reads only written rows.
// ----------------------------------------------------------------------------
module conv2d_window_filter_core
    import cwf_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,   // coef_index[5:0], coef_value[21:6], pixel[37:22]
    input  logic        s_axis_tuser,   // mode
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [63:0] m_axis_tdata,   // sum[39:0], out_row[51:40], out_col[61:52]
    output logic        m_axis_tlast,   // last_in_row
    output logic        m_axis_tuser,   // last_in_frame
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [12:0] cfg_data
);

    logic [2:0]  kernel_reg;
    logic [10:0] width_reg;
    logic [12:0] height_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kernel_reg <= 3'd3;
            width_reg  <= 11'd640;
            height_reg <= 13'd480;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_KERNEL: kernel_reg <= cfg_data[2:0];
                REG_WIDTH:  width_reg  <= cfg_data[10:0];
                REG_HEIGHT: height_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // effective geometry
    logic [KSEL_BITS-1:0] k;
    logic [KSEL_BITS-1:0] koff;
    logic [WC_BITS-1:0]   w;
    logic [HC_BITS-1:0]   h;
    logic [KSEL_BITS-1:0] pad;
    logic [COL_BITS-1:0]  wp;
    logic [ROW_BITS:0]    hp;

    always_comb
    begin
        k = (kernel_reg == 3'd0) ? KSEL_BITS'(1) : KSEL_BITS'(kernel_reg);
        koff = KSEL_BITS'(MAX_KERNEL) - k;
        if (width_reg == 11'd0)
            w = WC_BITS'(1);
        else if (width_reg > 11'(MAX_WIDTH))
            w = WC_BITS'(MAX_WIDTH);
        else
            w = WC_BITS'(width_reg);
        if (height_reg == 13'd0)
            h = HC_BITS'(1);
        else if (height_reg > 13'(MAX_HEIGHT))
            h = HC_BITS'(MAX_HEIGHT);
        else
            h = HC_BITS'(height_reg);
        pad = k >> 1;
        wp  = COL_BITS'(w) + COL_BITS'({pad, 1'b0});
        hp  = (ROW_BITS+1)'(h) + (ROW_BITS+1)'({pad, 1'b0});
    end

    // pipeline control
    logic s0_ready;
    logic s1_valid_reg, s2_valid_reg, s3_valid_reg;
    logic out_valid_reg;
    logic adv;

    assign adv           = !out_valid_reg || m_axis_tready;
    assign s_axis_tready = adv;
    assign s0_ready      = s_axis_tvalid && adv;

    logic    mode;
    sample_t pix;
    assign mode = s_axis_tuser;
    assign pix  = sample_t'(s_axis_tdata[37:22]);

    // coefficient store, flattened by row-major index
    coef_t coef_reg [COEF_COUNT];
    logic [CIDX_BITS-1:0] cidx;
    assign cidx = s_axis_tdata[5:0];

    // writes trail by one step so a sum in flight keeps its kernel
    logic                 cw_valid_reg;
    logic [CIDX_BITS-1:0] cw_idx_reg;
    coef_t                cw_val_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cw_valid_reg <= 1'b0;
            cw_idx_reg   <= '0;
            cw_val_reg   <= '0;
            for (int i = 0; i < COEF_COUNT; i++)
                coef_reg[i] <= '0;
        end
        else if (adv)
        begin
            cw_valid_reg <= s0_ready && mode == MODE_COEF && cidx < CIDX_BITS'(COEF_COUNT);
            cw_idx_reg   <= cidx;
            cw_val_reg   <= coef_t'(s_axis_tdata[21:6]);
            if (cw_valid_reg)
                coef_reg[cw_idx_reg] <= cw_val_reg;
        end
    end

    // counters
    logic [COL_BITS-1:0] col_reg;
    logic [ROW_BITS-1:0] row_reg;
    logic [2:0]          slot_reg;
    logic                pix_go;

    assign pix_go = s0_ready && mode == MODE_PIXEL;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg  <= '0;
            row_reg  <= '0;
            slot_reg <= '0;
        end
        else if (pix_go)
        begin
            if (COL_BITS'(col_reg + 1'b1) >= wp)
            begin
                col_reg <= '0;
                if ((ROW_BITS+1)'(row_reg) + 1'b1 >= hp)
                begin
                    row_reg  <= '0;
                    slot_reg <= '0;
                end
                else
                begin
                    row_reg  <= row_reg + 1'b1;
                    slot_reg <= (slot_reg == 3'(MAX_KERNEL - 1)) ? 3'd0 : slot_reg + 3'd1;
                end
            end
            else
            begin
                col_reg <= col_reg + 1'b1;
            end
        end
    end

    // result test in stage 0
    logic                 hit;
    logic [ROW_BITS-1:0]  oy;
    logic [COL_BITS-1:0]  ox;

    always_comb
    begin
        oy  = row_reg - ROW_BITS'(k - 1'b1);
        ox  = col_reg - COL_BITS'(k - 1'b1);
        hit = pix_go && row_reg >= ROW_BITS'(k - 1'b1) && col_reg >= COL_BITS'(k - 1'b1)
              && (ROW_BITS+1)'(oy) < (ROW_BITS+1)'(h) && ox < COL_BITS'(w);
    end

    // line stores; the window reads the previous MAX_KERNEL-1 rows, the current row is the pixel itself
    sample_t rd_data [MAX_KERNEL];
    logic    wr_in_range;
    assign wr_in_range = col_reg < COL_BITS'(STORE_COLS);

    for (genvar g = 0; g < MAX_KERNEL; g++)
    begin : g_line
        cwf_line_store u_line (
            .clk     (clk),
            .wr_en   (pix_go && wr_in_range && slot_reg == 3'(g)),
            .wr_addr (col_reg),
            .wr_data (pix),
            .rd_en   (pix_go),
            .rd_addr (col_reg),
            .rd_data (rd_data[g])
        );
    end

    // stage 1 holds the fresh pixel and slot alongside the registered reads
    sample_t pix1_reg;
    logic [2:0] slot1_reg;
    tag_t tag1_reg, tag2_reg, tag3_reg;
    logic hit1_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            hit1_reg     <= 1'b0;
        end
        else if (adv)
        begin
            s1_valid_reg <= pix_go;
            hit1_reg     <= hit;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            pix1_reg  <= pix;
            slot1_reg <= slot_reg;
            tag1_reg.out_row       <= OROW_BITS'(oy);
            tag1_reg.out_col       <= OCOL_BITS'(ox);
            tag1_reg.last_in_row   <= ox == COL_BITS'(w - 1'b1);
            tag1_reg.last_in_frame <= ox == COL_BITS'(w - 1'b1)
                                      && (ROW_BITS+1)'(oy) == (ROW_BITS+1)'(h - 1'b1);
        end
    end

    // column entering the window: index ky holds row r-(MAX_KERNEL-1-ky)
    sample_t col_in [MAX_KERNEL];

    always_comb
    begin
        for (int ky = 0; ky < MAX_KERNEL; ky++)
        begin
            logic [3:0] s;
            s = 4'(slot1_reg) + 4'(1) + 4'(ky);
            if (s >= 4'(MAX_KERNEL))
                s = s - 4'(MAX_KERNEL);
            if (ky == MAX_KERNEL - 1)
                col_in[ky] = pix1_reg;
            else
                col_in[ky] = rd_data[s[2:0]];
        end
    end

    // window of tap cells; cell [ky][kx] holds column c-(MAX_KERNEL-1-kx), shifting leftward
    sample_t win [MAX_KERNEL][MAX_KERNEL];
    sum_t    part [MAX_KERNEL][MAX_KERNEL+1];
    sum_t    row_sum [MAX_KERNEL];

    for (genvar gy = 0; gy < MAX_KERNEL; gy++)
    begin : g_row
        assign part[gy][0] = '0;
        for (genvar gx = 0; gx < MAX_KERNEL; gx++)
        begin : g_tap
            sample_t              nxt;
            logic                 in_k;
            logic [CIDX_BITS-1:0] ci;
            // lower right K by K cells are active
            assign in_k = gy >= int'(koff) && gx >= int'(koff);
            assign ci   = in_k ? CIDX_BITS'((gy - int'(koff)) * int'(k) + gx - int'(koff))
                               : '0;
            // the rightmost cell takes the new column, others take their right neighbor
            assign nxt = (gx == MAX_KERNEL - 1) ? col_in[gy]
                       : win[gy][(gx < MAX_KERNEL - 1) ? gx + 1 : gx];
            cwf_tap_cell u_cell (
                .clk        (clk),
                .advance    (adv && s1_valid_reg),
                .sample_in  (nxt),
                .sample_out (win[gy][gx]),
                .coef       (coef_reg[ci]),
                .enable     (in_k),
                .sum_in     (part[gy][gx]),
                .sum_out    (part[gy][gx+1])
            );
        end
        assign row_sum[gy] = part[gy][MAX_KERNEL];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s2_valid_reg <= 1'b0;
        else if (adv)
            s2_valid_reg <= s1_valid_reg && hit1_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
            tag2_reg <= tag1_reg;
    end

    // registered row sums
    sum_t row_sum_reg [MAX_KERNEL];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s3_valid_reg <= 1'b0;
        else if (adv)
            s3_valid_reg <= s2_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            tag3_reg <= tag2_reg;
            for (int ky = 0; ky < MAX_KERNEL; ky++)
                row_sum_reg[ky] <= row_sum[ky];
        end
    end

    // output register
    sum_t out_sum_reg;
    tag_t out_tag_reg;
    sum_t total;

    always_comb
    begin
        total = '0;
        for (int ky = 0; ky < MAX_KERNEL; ky++)
            total = total + row_sum_reg[ky];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (adv)
            out_valid_reg <= s3_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            out_sum_reg <= total;
            out_tag_reg <= tag3_reg;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {2'b00, out_tag_reg.out_col, out_tag_reg.out_row, out_sum_reg};
    assign m_axis_tlast  = out_tag_reg.last_in_row;
    assign m_axis_tuser  = out_tag_reg.last_in_frame;

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed under stall");
    a_frame: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser |-> m_axis_tlast)
        else $error("frame end without row end");
    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid_reg |-> s_axis_tready)
        else $error("stall with empty output");

endmodule

/* sim/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the k by k window filter core
// ----------------------------------------------------------------------------
// items go to the core from a queue through a clocked driver; a clocked
// monitor runs every accepted item through a local window-sum predictor and
// checks each result field by field against the oldest expected sum. frames
// use small sizes, except for the clamped width extreme; an oversized height
// is cut short by a reconfiguration, and one kernel change lands mid-row.
// both handshakes idle at random, and one long output hold-off fills the core.
// ----------------------------------------------------------------------------
module tb_top;

    timeunit 1ns;
    timeprecision 1ps;

    import cwf_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int SETTLE      = 8;

    typedef struct {
        logic        mode;
        logic [5:0]  idx;
        logic [15:0] cv;
        logic [15:0] px;
    } item_t;

    typedef struct {
        logic [39:0] sum;
        logic [11:0] row;
        logic [9:0]  col;
        logic        lir;
        logic        lif;
    } window_sum_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [39:0] s_axis_tdata = '0;
    logic        s_axis_tuser = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [63:0] m_axis_tdata;
    logic        m_axis_tlast;
    logic        m_axis_tuser;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index = '0;
    logic [12:0] cfg_data = '0;

    item_t       pending_items[$];
    window_sum_t expected_sums[$];

    // predictor state
    coef_t   coef_mem[COEF_COUNT];
    sample_t row_mem[MAX_KERNEL][STORE_COLS];
    int      cnt_r = 0, cnt_c = 0;
    int      pk = 3, pw = 640, ph = 480;

    // stimulus side mirror of the counters
    int gen_r = 0, gen_c = 0;
    int gk = 3, gw = 640, gh = 480;

    int  errors = 0, cycles = 0, items_in = 0, sums_out = 0, frames = 0;
    logic in_taken = 1'b0, out_taken = 1'b0, hold = 1'b0;
    int  in_gap = 0, out_gap = 0;
    logic burst = 1'b0;

    conv2d_window_filter_core uut (.*);

    always #2 clk = ~clk;

    function automatic int clamp_int(int v, int lo, int hi);
        return (v < lo) ? lo : (v > hi) ? hi : v;
    endfunction

    function automatic logic [15:0] pick16();
        case ($urandom_range(0, 7))
            0: return 16'h8000;
            1: return 16'h7fff;
            2: return 16'h0000;
            3: return 16'hffff;
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic forecast_window(item_t it);
        int pad, wp, hp, r, c, oy, ox, slot;
        longint acc;
        window_sum_t e;
        if (it.mode == MODE_COEF) begin
            if (it.idx < COEF_COUNT)
                coef_mem[it.idx] = coef_t'(it.cv);
            return;
        end
        pad = pk / 2;
        wp = pw + 2 * pad;
        hp = ph + 2 * pad;
        r = cnt_r;
        c = cnt_c;
        if (c < STORE_COLS)
            row_mem[r % MAX_KERNEL][c] = sample_t'(it.px);
        if (c + 1 >= wp) begin
            cnt_c = 0;
            cnt_r = (r + 1 >= hp) ? 0 : r + 1;
        end
        else
            cnt_c = c + 1;
        if (r < pk - 1 || c < pk - 1)
            return;
        oy = r - (pk - 1);
        ox = c - (pk - 1);
        if (oy >= ph || ox >= pw)
            return;
        acc = 0;
        for (int ky = 0; ky < pk; ky++) begin
            slot = (oy + ky) % MAX_KERNEL;
            for (int kx = 0; kx < pk; kx++)
                if (ox + kx < STORE_COLS)
                    acc += longint'(row_mem[slot][ox + kx]) * longint'(coef_mem[ky * pk + kx]);
        end
        e.sum = acc[39:0];
        e.row = oy[11:0];
        e.col = ox[9:0];
        e.lir = (ox == pw - 1);
        e.lif = (ox == pw - 1) && (oy == ph - 1);
        expected_sums.push_back(e);
    endtask

    task automatic report_mismatch(string what, longint got, longint want);
        $display("mismatch %s: got %0h expected %0h at cycle %0d", what, got, want, cycles);
        errors++;
    endtask

    // monitor
    always @(posedge clk) begin
        window_sum_t e;
        in_taken <= s_axis_tvalid && s_axis_tready;
        out_taken <= m_axis_tvalid && m_axis_tready;
        if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                REG_KERNEL: pk = clamp_int(int'(cfg_data[2:0]), 1, MAX_KERNEL);
                REG_WIDTH:  pw = clamp_int(int'(cfg_data[10:0]), 1, MAX_WIDTH);
                REG_HEIGHT: ph = clamp_int(int'(cfg_data[12:0]), 1, MAX_HEIGHT);
                default: ;
            endcase
        end
        if (s_axis_tvalid && s_axis_tready) begin
            item_t it;
            it.mode = s_axis_tuser;
            it.idx = s_axis_tdata[5:0];
            it.cv = s_axis_tdata[21:6];
            it.px = s_axis_tdata[37:22];
            forecast_window(it);
            items_in++;
        end
        if (m_axis_tvalid && m_axis_tready) begin
            sums_out++;
            if (expected_sums.size() == 0)
                report_mismatch("unexpected item", longint'(m_axis_tdata[39:0]), 0);
            else begin
                e = expected_sums.pop_front();
                if (m_axis_tdata[39:0] !== e.sum)
                    report_mismatch("sum", longint'(m_axis_tdata[39:0]), longint'(e.sum));
                if (m_axis_tdata[51:40] !== e.row)
                    report_mismatch("out_row", longint'(m_axis_tdata[51:40]), longint'(e.row));
                if (m_axis_tdata[61:52] !== e.col)
                    report_mismatch("out_col", longint'(m_axis_tdata[61:52]), longint'(e.col));
                if (m_axis_tlast !== e.lir)
                    report_mismatch("last_in_row", longint'(m_axis_tlast), longint'(e.lir));
                if (m_axis_tuser !== e.lif)
                    report_mismatch("last_in_frame", longint'(m_axis_tuser), longint'(e.lif));
            end
        end
    end

    // driver
    always @(negedge clk) begin
        item_t it;
        if (rst_n && (!s_axis_tvalid || in_taken)) begin
            if (in_gap > 0) begin
                in_gap <= in_gap - 1;
                s_axis_tvalid <= 1'b0;
            end
            else if (pending_items.size() > 0) begin
                it = pending_items.pop_front();
                s_axis_tuser <= it.mode;
                s_axis_tdata <= {2'b00, it.px, it.cv, it.idx};
                s_axis_tvalid <= 1'b1;
                if ($urandom_range(0, 63) == 0)
                    burst <= ~burst;
                in_gap <= burst ? 0 : $urandom_range(0, 19);
            end
            else
                s_axis_tvalid <= 1'b0;
        end
    end

    // receiver
    always @(negedge clk) begin
        if (rst_n) begin
            if (out_taken)
                out_gap <= burst ? 0 : $urandom_range(0, 19);
            else if (out_gap > 0)
                out_gap <= out_gap - 1;
            m_axis_tready <= !hold && (out_taken ? burst : out_gap == 0);
        end
    end

    // long output hold-off while the input keeps coming
    initial begin
        while (sums_out < 300)
            @(negedge clk);
        hold <= 1'b1;
        repeat (500) @(negedge clk);
        hold <= 1'b0;
    end

    always @(posedge clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("== FAIL ==");
            $finish;
        end
    end

    task automatic wait_idle();
        while (pending_items.size() > 0 || s_axis_tvalid || expected_sums.size() > 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [12:0] val);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
        case (idx)
            REG_KERNEL: gk = clamp_int(int'(val[2:0]), 1, MAX_KERNEL);
            REG_WIDTH:  gw = clamp_int(int'(val[10:0]), 1, MAX_WIDTH);
            REG_HEIGHT: gh = clamp_int(int'(val[12:0]), 1, MAX_HEIGHT);
            default: ;
        endcase
    endtask

    task automatic setup_frame(int k, int w, int h);
        wait_idle();
        write_reg(REG_KERNEL, 13'(k));
        write_reg(REG_WIDTH, 13'(w));
        write_reg(REG_HEIGHT, 13'(h));
    endtask

    task automatic push_coef(int idx, logic [15:0] v);
        item_t it;
        it.mode = MODE_COEF;
        it.idx = 6'(idx);
        it.cv = v;
        it.px = 16'($urandom);
        pending_items.push_back(it);
    endtask

    task automatic push_pixel(logic [15:0] v);
        item_t it;
        int pad;
        it.mode = MODE_PIXEL;
        it.idx = 6'($urandom);
        it.cv = 16'($urandom);
        it.px = v;
        pending_items.push_back(it);
        pad = gk / 2;
        if (gen_c + 1 >= gw + 2 * pad) begin
            gen_c = 0;
            gen_r = (gen_r + 1 >= gh + 2 * pad) ? 0 : gen_r + 1;
        end
        else
            gen_c++;
    endtask

    // pixels until the padded frame closes, with stray coefficient items
    task automatic finish_frame(int coef_odds);
        do begin
            if ($urandom_range(0, coef_odds) == 0)
                push_coef($urandom_range(0, 63), pick16());
            push_pixel(pick16());
        end while (gen_r != 0 || gen_c != 0);
        frames++;
    endtask

    task automatic load_kernel(int k);
        for (int i = 0; i < k * k; i++)
            push_coef(i, pick16());
    endtask

    initial begin
        int k;
        int base;
        foreach (coef_mem[i])
            coef_mem[i] = '0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // short directed frame: coefficient and pixel extremes, ignored index
        setup_frame(3, 2, 1);
        push_coef(0, 16'h7fff);
        push_coef(4, 16'h8000);
        push_coef(8, 16'h7fff);
        push_coef(63, 16'h1234);
        push_coef(49, 16'h4321);
        push_coef(2, 16'hffff);
        for (int i = 0; i < 12; i++)
            push_pixel((i % 2) ? 16'h8000 : 16'h7fff);
        frames++;

        // clamped sizes, largest kernel, even kernel
        setup_frame(0, 0, 0);
        load_kernel(1);
        finish_frame(4);
        setup_frame(7, 1, 1);
        load_kernel(7);
        finish_frame(8);
        setup_frame(4, 3, 2);
        load_kernel(4);
        finish_frame(8);
        setup_frame(1, 2047, 1);
        load_kernel(1);
        finish_frame(200);

        // oversized height cut short, then the row counter wraps
        setup_frame(1, 1, 8191);
        load_kernel(1);
        for (int i = 0; i < 64; i++)
            push_pixel(pick16());
        setup_frame(3, 4, 2);
        finish_frame(30);
        load_kernel(3);
        finish_frame(30);

        // kernel change in the middle of a row
        setup_frame(5, 8, 3);
        load_kernel(5);
        finish_frame(30);
        for (int i = 0; i < 30; i++)
            push_pixel(pick16());
        setup_frame(3, 8, 3);
        finish_frame(30);

        // random frames
        base = items_in;
        while (items_in - base < 250) begin
            k = $urandom_range(0, 7);
            setup_frame(k, $urandom_range(0, 12), $urandom_range(0, 6));
            if ($urandom_range(0, 3) != 0)
                load_kernel(clamp_int(k, 1, MAX_KERNEL));
            finish_frame(12);
            wait_idle();
        end

        wait_idle();
        repeat (20) @(posedge clk);
        $display("%0d frames, %0d items in, %0d window sums checked", frames, items_in, sums_out);
        $display("kernels 1 to 7 with clamping, widths to 1024, mid-row kernel change, %0d errors",
                 errors);
        if (errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
